[rtl/wms_pkg.sv]
// windowed mean square: shared widths, register indexes and limits
// no dependencies; used by the top level, the term ring and the port checker
package wms_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 16;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int WLEN_W   = 11;
	localparam int SCALE_W  = 17;
	localparam int PROD_W   = SQ_W + SCALE_W;
	localparam int TERM_W   = 31;
	localparam int SUM_W    = 41;
	localparam int FRAC_SH  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SCALE_W;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TERM_SCALE = 2'd1;

	localparam logic [WLEN_W-1:0]  WLEN_RESET  = 11'd1024;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd64;
	localparam logic [SCALE_W-1:0] SCALE_MAX   = 17'd65536;

endpackage

[rtl/wms_ring.sv]
// windowed mean square: ring of stored terms, one synchronous read and one write port
// entries at or above the fill mark read as zero; depends on wms_pkg
module wms_ring #(
	parameter int DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	output logic [wms_pkg::TERM_W-1:0]  rd_data,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  logic [wms_pkg::TERM_W-1:0]  wr_data
);
	import wms_pkg::*;

	localparam int ADDR_W = $clog2(DEPTH);

	logic [TERM_W-1:0] mem [DEPTH];
	logic [TERM_W-1:0] rd_data_q;
	logic              rd_vld_q;
	logic [ADDR_W:0]   fill_q;

	// the fill mark grows only on a write at the mark, so it counts the written prefix of the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en && ((ADDR_W+1)'(wr_addr) == fill_q)) begin
				fill_q <= fill_q + (ADDR_W+1)'(1);
			end
			if (rd_en) begin
				rd_vld_q <= (ADDR_W+1)'(rd_addr) < fill_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

[rtl/windowed_mean_square.sv]
// windowed mean square: top level with config registers, sequencer, multipliers and sum
// depends on wms_pkg and wms_ring
//
// usage:
//   sample requests enter on in_valid/in_ready; each gives one mean_square result
//   on out_valid/out_ready: the sum of the last window_len squared samples, each times
//   term_scale in units of 2^-16; window_len is clamped to 1..MAX_WINDOW.
//   config writes (cfg_we, cfg_index, cfg_data) take effect at once; the user must
//   make them only while idle (not enforced here); a new window length needs a reset.
//   an accepted sample runs through the ring read, the square (ST_SQ), the scale
//   multiply (ST_SCALE) and the write-back (ST_DONE) in turn; out_valid is registered
//   at the write-back, and no new sample is taken until the write-back is done.
//   a stalled receiver holds the result in the output register; the next
//   sample is still accepted and runs up to the write-back step, where it
//   waits until the held result is taken.
//   reset clears the sum, the ring position and the ring fill mark, so the
//   ring reads as all zero; no clearing pass is needed.
module windowed_mean_square #(
	parameter int MAX_WINDOW = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [wms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wms_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [wms_pkg::SAMPLE_W-1:0] sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [wms_pkg::SUM_W-1:0]          mean_square
);
	import wms_pkg::*;

	localparam int ADDR_W = $clog2(MAX_WINDOW);
	localparam int CW     = (ADDR_W + 1 > WLEN_W) ? ADDR_W + 1 : WLEN_W;
	localparam logic [CW-1:0] MAX_CW = CW'(MAX_WINDOW);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SQ    = 2'd1;
	localparam logic [1:0] ST_SCALE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]         state_q;
	logic [WLEN_W-1:0]  window_len_q;
	logic [SCALE_W-1:0] term_scale_q;
	logic [ADDR_W-1:0]  write_pos_q;
	logic [SUM_W-1:0]   sum_q;
	logic               out_valid_q;
	logic [SUM_W-1:0]   mean_square_q;

	logic [MAG_W-1:0]   mag_s1;
	logic [ADDR_W-1:0]  pos_s1;
	logic [SQ_W-1:0]    sq_s2;
	logic [TERM_W-1:0]  old_s2;
	logic [PROD_W-1:0]  prod_s3;

	logic [CW-1:0]      eff_w;
	logic [CW-1:0]      wlen_ext;
	logic [ADDR_W-1:0]  pos_eff;
	logic [CW-1:0]      pos_nxt;
	logic [SCALE_W-1:0] scale_sat;
	logic [MAG_W-1:0]   sample_u;
	logic [MAG_W-1:0]   mag;
	logic [TERM_W-1:0]  term;
	logic [TERM_W-1:0]  rd_data;
	logic               accept;
	logic               commit;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign commit   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		wlen_ext = CW'(window_len_q);
		if (wlen_ext == '0) begin
			eff_w = CW'(1);
		end else if (wlen_ext > MAX_CW) begin
			eff_w = MAX_CW;
		end else begin
			eff_w = wlen_ext;
		end
	end

	assign pos_eff   = (CW'(write_pos_q) >= eff_w) ? '0 : write_pos_q;
	assign pos_nxt   = CW'(pos_s1) + CW'(1);
	assign scale_sat = (term_scale_q > SCALE_MAX) ? SCALE_MAX : term_scale_q;
	assign sample_u  = $unsigned(sample);
	assign mag       = sample_u[MAG_W-1] ? (~sample_u + MAG_W'(1)) : sample_u;
	assign term      = prod_s3[FRAC_SH +: TERM_W];

	wms_ring #(
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (pos_eff),
		.rd_data (rd_data),
		.wr_en   (commit),
		.wr_addr (pos_s1),
		.wr_data (term)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WLEN_RESET;
			term_scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LEN: window_len_q <= cfg_data[WLEN_W-1:0];
				REG_TERM_SCALE: term_scale_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			write_pos_q <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ:    state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_DONE;
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (commit) begin
				sum_q       <= sum_q - SUM_W'(old_s2) + SUM_W'(term);
				write_pos_q <= (pos_nxt >= eff_w) ? '0 : pos_nxt[ADDR_W-1:0];
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1 <= mag;
			pos_s1 <= pos_eff;
		end
		if (state_q == ST_SQ) begin
			sq_s2  <= SQ_W'(mag_s1) * SQ_W'(mag_s1);
			old_s2 <= rd_data;
		end
		if (state_q == ST_SCALE) begin
			prod_s3 <= PROD_W'(sq_s2) * PROD_W'(scale_sat);
		end
		if (commit) begin
			mean_square_q <= sum_q - SUM_W'(old_s2) + SUM_W'(term);
		end
	end

	assign out_valid   = out_valid_q;
	assign mean_square = mean_square_q;

endmodule

[rtl/wms_checker.sv]
// windowed mean square: port-level checker and its bind to the top level
// depends on wms_pkg and windowed_mean_square
module wms_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [wms_pkg::SUM_W-1:0]   mean_square
);
	import wms_pkg::*;

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_square))
		else $error("result changed while stalled");

	// one request in flight: ready drops after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after accept");

	// ready only drops because a request was taken
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("block went busy without a request");

	// a new result follows only from a request in flight
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid || $past(!in_ready))
		else $error("result without a request in flight");

endmodule

bind windowed_mean_square wms_checker u_wms_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.mean_square (mean_square)
);
